// ===== hdl/ring_stamp_cover_check_top_macros.svh =====
`ifndef RING_STAMP_COVER_CHECK_TOP_MACROS_SVH
`define RING_STAMP_COVER_CHECK_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RSCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RSCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rscc_pkg.sv =====
package rscc_pkg;

  localparam int MAX_ROWS  = 4096;
  localparam int MAX_COLS  = 1024;
  localparam int ROWS_W    = 13;
  localparam int COLS_W    = 11;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int COL_IDX_W = $clog2(MAX_COLS);
  localparam int VROW_W    = ROW_IDX_W + 1;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_SEL_BIT = 2;

  typedef logic [ROWS_W-1:0]    rows_reg_t;
  typedef logic [COLS_W-1:0]    cols_reg_t;
  typedef logic [ROW_IDX_W-1:0] row_idx_t;
  typedef logic [COL_IDX_W-1:0] col_idx_t;
  typedef logic [VROW_W-1:0]    vrow_t;

  localparam rows_reg_t ROWS_RESET = rows_reg_t'(3);
  localparam cols_reg_t COLS_RESET = cols_reg_t'(3);

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // one line buffer entry at column c
  typedef struct packed {
    logic pix_r1;   // pixel one row up, column c
    logic pix_r2;   // pixel two rows up, column c
    logic ctr_r2;   // centre flag two rows up, column c-1
    logic ctr_r3;   // centre flag three rows up, column c-1
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // work carried from the issue stage to the check stage
  typedef struct packed {
    logic     pix;
    col_idx_t col;
    logic     row_ge1;
    logic     row_ge2;
    logic     row_ge3;
    logic     ctr_en;
    logic     col_ge1;
    logic     col_ge2;
    logic     last_col;
    logic     last_step;
  } stage_t;

endpackage

// ===== hdl/rscc_ram.sv =====
module rscc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ring_stamp_cover_check_top.sv =====
// 3x3 ring opening check on a binary raster image.
// pixel channel: pixel_valid / pixel_stall / pixel_set, one pixel per request,
// raster order, frame_rows x frame_cols (register 0 at byte 0, register 1 at 4).
// result channel: result_valid / result_stall / reproducible, one request per
// frame, 1 when the image equals its ring stamp coverage.
// throughput: one pixel per cycle inside a frame. after the last pixel the
// block flushes the last two rows through the line buffer, one column a cycle
// unless a stalled verdict holds the last column, with pixel_stall high
// throughout; the verdict shows after the flush ends. the single line buffer
// port pair (read one column ahead, write back in the next cycle) sets this.
// the next frame may start while the verdict still waits; if the previous
// verdict is still stalled at the end of the next flush, the flush holds on
// its last column until the result register frees.
// reset (synchronous, rst high) restores 3x3 frame size and an empty frame;
// unwritten line buffer values are masked. sizes must be written only between
// frames, which the block does not enforce; 0 acts as 1, oversize as the max.
`include "ring_stamp_cover_check_top_macros.svh"

module ring_stamp_cover_check_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rscc_pkg::ADDR_W-1:0]    paddr,
  input  logic [rscc_pkg::DATA_W-1:0]    pwdata,
  output logic [rscc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic                           pixel_set,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           reproducible
);

  rscc_pkg::rows_reg_t rows_raw;
  rscc_pkg::cols_reg_t cols_raw;
  rscc_pkg::row_idx_t  row_last;
  rscc_pkg::col_idx_t  col_last;
  rscc_pkg::vrow_t     end_row;
  logic                cfg_wr;

  rscc_pkg::vrow_t     row_cnt;
  rscc_pkg::col_idx_t  col_cnt;
  logic                flushing;
  logic                last_col0;
  logic                final_pos;
  logic                issue;
  rscc_pkg::stage_t    s0;
  rscc_pkg::stage_t    s1;
  logic                s1_valid;

  logic [rscc_pkg::LINE_W-1:0] ram_rd;
  rscc_pkg::line_t     line_rd;
  rscc_pkg::line_t     line_wr;
  rscc_pkg::line_t     fwd_data;
  logic                fwd_hit;

  logic [2:0][2:0]     pw;
  logic [2:0][2:0]     pw_next;
  logic [2:0][2:0]     cw;
  logic [2:0][2:0]     cw_next;
  logic                p_m1, p_m2, c_m2, c_m3;
  logic                centre;
  logic [2:0]          ctr_col;
  logic                cov0, cov1, cov2;
  logic                bad;
  logic                mismatch;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_raw <= rscc_pkg::ROWS_RESET;
      cols_raw <= rscc_pkg::COLS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[rscc_pkg::REG_SEL_BIT])
        rscc_pkg::REG_ROWS: rows_raw <= pwdata[rscc_pkg::ROWS_W-1:0];
        rscc_pkg::REG_COLS: cols_raw <= pwdata[rscc_pkg::COLS_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[rscc_pkg::REG_SEL_BIT])
      rscc_pkg::REG_ROWS: prdata = {{(rscc_pkg::DATA_W-rscc_pkg::ROWS_W){1'b0}}, rows_raw};
      rscc_pkg::REG_COLS: prdata = {{(rscc_pkg::DATA_W-rscc_pkg::COLS_W){1'b0}}, cols_raw};
    endcase
  end

  // effective last row and column
  always_comb begin
    if (rows_raw == '0) begin
      row_last = '0;
    end else if (rows_raw > rscc_pkg::rows_reg_t'(rscc_pkg::MAX_ROWS)) begin
      row_last = rscc_pkg::row_idx_t'(rscc_pkg::MAX_ROWS - 1);
    end else begin
      row_last = rscc_pkg::row_idx_t'(rows_raw - 1'b1);
    end
    if (cols_raw == '0) begin
      col_last = '0;
    end else if (cols_raw > rscc_pkg::cols_reg_t'(rscc_pkg::MAX_COLS)) begin
      col_last = rscc_pkg::col_idx_t'(rscc_pkg::MAX_COLS - 1);
    end else begin
      col_last = rscc_pkg::col_idx_t'(cols_raw - 1'b1);
    end
  end

  // two blank rows past the frame drain the pending checks
  assign end_row   = {1'b0, row_last} + rscc_pkg::vrow_t'(2);
  assign flushing  = row_cnt > {1'b0, row_last};
  assign last_col0 = col_cnt == col_last;
  assign final_pos = flushing & last_col0 & (row_cnt == end_row);
  assign issue     = flushing ? !(final_pos & result_valid & result_stall) : pixel_valid;
  assign pixel_stall = flushing;

  always_comb begin
    s0.pix       = !flushing & pixel_set;
    s0.col       = col_cnt;
    s0.row_ge1   = row_cnt != '0;
    s0.row_ge2   = row_cnt >= rscc_pkg::vrow_t'(2);
    s0.row_ge3   = row_cnt >= rscc_pkg::vrow_t'(3);
    s0.col_ge1   = col_cnt != '0;
    s0.col_ge2   = col_cnt >= rscc_pkg::col_idx_t'(2);
    s0.ctr_en    = s0.row_ge2 & s0.col_ge2 & !flushing;
    s0.last_col  = last_col0;
    s0.last_step = final_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (issue) begin
      if (last_col0) begin
        col_cnt <= '0;
        row_cnt <= final_pos ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= s0;
    end
  end

  rscc_ram #(
    .WIDTH(rscc_pkg::LINE_W),
    .DEPTH(rscc_pkg::MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1.col),
    .wr_data (line_wr),
    .rd_en   (issue),
    .rd_addr (col_cnt),
    .rd_data (ram_rd)
  );

  // same column read and written on one edge (single column frames)
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= issue & s1_valid & (col_cnt == s1.col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= line_wr;
  end

  // check stage
  always_comb begin
    line_rd = fwd_hit ? fwd_data : rscc_pkg::line_t'(ram_rd);
    p_m1 = line_rd.pix_r1 & s1.row_ge1;
    p_m2 = line_rd.pix_r2 & s1.row_ge2;
    c_m2 = line_rd.ctr_r2 & s1.row_ge2;
    c_m3 = line_rd.ctr_r3 & s1.row_ge3;

    pw_next = {{s1.pix, p_m1, p_m2}, pw[2], pw[1]};
    centre  = s1.ctr_en & (&pw_next[0]) & (&pw_next[2]) & pw_next[1][0] & pw_next[1][2];
    ctr_col = s1.col_ge2 ? {centre, c_m2, c_m3} : 3'b000;
    cw_next = {ctr_col, cw[2], cw[1]};

    // target pixels sit two rows up: columns c-2, c-1 and c
    cov0 = (|cw_next[0]) | (|cw_next[2]) | cw_next[1][0] | cw_next[1][2];
    cov1 = (|cw_next[1]) | cw_next[2][0] | cw_next[2][2];
    cov2 = |cw_next[2];
    bad  = s1.row_ge2 & ((s1.col_ge2 & (pw_next[0][0] != cov0))
                       | (s1.last_col & s1.col_ge1 & (pw_next[1][0] != cov1))
                       | (s1.last_col & (pw_next[2][0] != cov2)));

    line_wr.pix_r1 = s1.pix;
    line_wr.pix_r2 = p_m1;
    line_wr.ctr_r2 = centre;
    line_wr.ctr_r3 = c_m2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw <= '0;
      cw <= '0;
    end else if (s1_valid) begin
      pw <= pw_next;
      cw <= cw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid & !result_stall) begin
        result_valid <= 1'b0;
      end
      if (s1_valid) begin
        if (s1.last_step) begin
          result_valid <= 1'b1;
          mismatch     <= 1'b0;
        end else begin
          mismatch <= mismatch | bad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid & s1.last_step) begin
      reproducible <= !(mismatch | bad);
    end
  end

  `RSCC_ASSERT_NEXT(a_verdict_loads, s1_valid && s1.last_step, result_valid && !mismatch, "frame end did not load the verdict")
  `RSCC_ASSERT_SAME(a_fwd_has_item, fwd_hit, s1_valid, "forwarded line without an item in the check stage")
  `RSCC_ASSERT_SAME(a_last_step_room, issue && final_pos, !result_valid || !result_stall, "last flush step issued while the verdict register is held")

endmodule

// ===== sim/ring_stamp_cover_check_top_test.sv =====
class opening_verdict_board;
  int rows = 3;
  int cols = 3;
  bit frame_px[$];
  bit verdicts_due[$];
  int errors = 0;

  function void set_size(rscc_pkg::rows_reg_t r, rscc_pkg::cols_reg_t c);
    // zero acts as one, oversize clamps to the maximum
    rows = (r == 0) ? 1 : (int'(r) > rscc_pkg::MAX_ROWS) ? rscc_pkg::MAX_ROWS : int'(r);
    cols = (c == 0) ? 1 : (int'(c) > rscc_pkg::MAX_COLS) ? rscc_pkg::MAX_COLS : int'(c);
  endfunction

  function void flag(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endfunction

  function bit centre_at(int p, int q);
    int dp;
    int dq;
    if (p < 1 || p > rows - 2 || q < 1 || q > cols - 2) return 1'b0;
    for (dp = -1; dp <= 1; dp++)
      for (dq = -1; dq <= 1; dq++)
        if ((dp != 0 || dq != 0) && !frame_px[(p + dp) * cols + q + dq]) return 1'b0;
    return 1'b1;
  endfunction

  function bit frame_verdict();
    bit covered;
    int p;
    int q;
    int dp;
    int dq;
    for (p = 0; p < rows; p++)
      for (q = 0; q < cols; q++) begin
        covered = 1'b0;
        for (dp = -1; dp <= 1; dp++)
          for (dq = -1; dq <= 1; dq++)
            if ((dp != 0 || dq != 0) && centre_at(p + dp, q + dq)) covered = 1'b1;
        if (covered != frame_px[p * cols + q]) return 1'b0;
      end
    return 1'b1;
  endfunction

  function void take_pixel(bit v);
    frame_px.push_back(v);
    if (frame_px.size() == rows * cols) begin
      verdicts_due.push_back(frame_verdict());
      frame_px.delete();
    end
  endfunction

  function void check_verdict(bit got);
    bit want;
    if (verdicts_due.size() == 0) begin
      flag("unexpected verdict", -1, got);
    end else begin
      want = verdicts_due.pop_front();
      if (want != got) flag("verdict", want, got);
    end
  endfunction
endclass

module ring_stamp_cover_check_top_test;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [rscc_pkg::ADDR_W-1:0] apb_addr_t;
  typedef logic [rscc_pkg::DATA_W-1:0] apb_data_t;
  localparam apb_addr_t ROWS_ADDR = apb_addr_t'(rscc_pkg::REG_ROWS) << rscc_pkg::REG_SEL_BIT;
  localparam apb_addr_t COLS_ADDR = apb_addr_t'(rscc_pkg::REG_COLS) << rscc_pkg::REG_SEL_BIT;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  apb_addr_t         paddr = '0;
  apb_data_t         pwdata = '0;
  apb_data_t         prdata;
  logic              pready;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic              pixel_set = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic              reproducible;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  bit frame_img[$];

  opening_verdict_board sb = new();

  ring_stamp_cover_check_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_set    (pixel_set),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .reproducible (reproducible)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // verdict side: check each taken verdict, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_verdict(reproducible);
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic apb_write(input apb_addr_t addr, input apb_data_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input apb_addr_t addr, output apb_data_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(input rscc_pkg::rows_reg_t r, input rscc_pkg::cols_reg_t c);
    apb_data_t got;
    apb_write(ROWS_ADDR, apb_data_t'(r));
    apb_write(COLS_ADDR, apb_data_t'(c));
    apb_read(ROWS_ADDR, got);
    if (got !== apb_data_t'(r)) sb.flag("frame_rows readback", int'(r), int'(got));
    apb_read(COLS_ADDR, got);
    if (got !== apb_data_t'(c)) sb.flag("frame_cols readback", int'(c), int'(got));
    sb.set_size(r, c);
  endtask

  task automatic send_pixel(input bit v);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_set <= v;
    @(posedge clk);
    // hold the request until it is taken
    while (pixel_stall) @(posedge clk);
    sb.take_pixel(v);
  endtask

  task automatic send_image();
    foreach (frame_img[i]) send_pixel(frame_img[i]);
  endtask

  // wait until every verdict is in and the flush has finished
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void build_frame(int rows, int cols);
    int style;
    int dens;
    int p;
    int q;
    int dp;
    int dq;
    int n;
    style = $urandom_range(9);
    frame_img.delete();
    if (style >= 7) begin
      case ($urandom_range(3))
        0: dens = 0;
        1: dens = 100;
        default: dens = $urandom_range(100);
      endcase
      for (n = 0; n < rows * cols; n++) frame_img.push_back($urandom_range(99) < dens);
    end else begin
      // union of rings around random centres is always reproducible
      case ($urandom_range(2))
        0: dens = 8;
        1: dens = 25;
        default: dens = 60;
      endcase
      for (n = 0; n < rows * cols; n++) frame_img.push_back(1'b0);
      for (p = 1; p < rows - 1; p++)
        for (q = 1; q < cols - 1; q++)
          if ($urandom_range(99) < dens)
            for (dp = -1; dp <= 1; dp++)
              for (dq = -1; dq <= 1; dq++)
                if (dp != 0 || dq != 0) frame_img[(p + dp) * cols + q + dq] = 1'b1;
      // near miss: one flipped pixel
      if (style >= 5) begin
        n = $urandom_range(rows * cols - 1);
        frame_img[n] = ~frame_img[n];
      end
    end
  endfunction

  initial begin
    int small_items;
    int nfr;
    int r;
    int c;
    small_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size is 3x3: lone ring, full block, empty frame
    frame_img = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
    send_image();
    frame_img = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
    send_image();
    frame_img = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_image();
    settle();
    // zero sizes act as a single pixel
    set_frame_size('0, '0);
    frame_img = '{1};
    send_image();
    frame_img = '{0};
    send_image();
    settle();
    // full-width register values read back unclamped
    set_frame_size(rscc_pkg::rows_reg_t'(8191), rscc_pkg::cols_reg_t'(2047));

    while (small_items < RANDOM_ITEMS) begin
      if (small_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 69;
      end else if (small_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      r = $urandom_range(1, 8);
      c = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) r = $urandom_range(9, 30);
      else if ($urandom_range(9) == 0) c = $urandom_range(9, 30);
      set_frame_size(rscc_pkg::rows_reg_t'(r), rscc_pkg::cols_reg_t'(c));
      nfr = $urandom_range(1, 4);
      repeat (nfr) begin
        build_frame(sb.rows, sb.cols);
        send_image();
        small_items += sb.rows * sb.cols;
      end
    end

    settle();
    repeat (2 * rscc_pkg::MAX_COLS + 16) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0 && sb.frame_px.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
